// ----- hdl/adm_pkg.sv -----
// -----------------------------------------------------------------------------
// adm_pkg
// Shared types, constants and arithmetic helpers for the channel downmixer.
// -----------------------------------------------------------------------------
package adm_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int MAX_CHANNELS = 8;
   localparam int NUM_SLOTS    = 8;
   localparam int COEF_WIDTH   = 18;
   localparam int FRAC_BITS    = 16;
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + 3;
   localparam int ACC_WIDTH    = SAMPLE_WIDTH + 21;
   localparam int RND_WIDTH    = ACC_WIDTH - FRAC_BITS;

   // Q1.16 coefficients, held as positive signed values
   localparam logic signed [COEF_WIDTH-1:0] COEF_SURR = 18'sd46341;
   localparam logic signed [ACC_WIDTH-1:0]  ROUND_HALF = ACC_WIDTH'(32768);

   // Configuration register indexes
   localparam logic CSR_FOLD_MODE      = 1'b0;
   localparam logic CSR_INPUT_CHANNELS = 1'b1;

   // Mix modes
   localparam logic [1:0] MODE_STEREO_MONO = 2'd0;
   localparam logic [1:0] MODE_MONO_STEREO = 2'd1;
   localparam logic [1:0] MODE_SURR_STEREO = 2'd2;
   localparam logic [1:0] MODE_ANY_MONO    = 2'd3;

   localparam logic [1:0] OUT_MONO   = 2'd1;
   localparam logic [1:0] OUT_STEREO = 2'd2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [SUM_WIDTH-1:0]    sum_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic signed [RND_WIDTH-1:0]    rnd_type;
   typedef sample_type [NUM_SLOTS-1:0]     frame_type;

   typedef enum logic [1:0] {
      SEL_AVG,
      SEL_DUP,
      SEL_SURR
   } mix_sel_type;

   // Pipeline advance strobes from the handshake control
   typedef struct packed {
      logic load_a;
      logic load_out;
   } stage_en_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_left;
      logic signed [SAMPLE_WIDTH-1:0] out_right;
      logic [1:0]                     out_channels;
      logic                           channel_error;
   } result_type;

   // round(65536 / n) for the averaging modes
   function automatic logic signed [COEF_WIDTH-1:0] avg_weight(input logic [3:0] n);
      logic signed [COEF_WIDTH-1:0] w;
      case (n)
         4'd1:    w = 18'sd65536;
         4'd2:    w = 18'sd32768;
         4'd3:    w = 18'sd21845;
         4'd4:    w = 18'sd16384;
         4'd5:    w = 18'sd13107;
         4'd6:    w = 18'sd10923;
         4'd7:    w = 18'sd9362;
         4'd8:    w = 18'sd8192;
         default: w = 18'sd0;
      endcase
      return w;
   endfunction

   // Round half up at the Q16 point, then clamp to the sample range
   function automatic sample_type round_sat(input acc_type acc);
      acc_type sum;
      rnd_type q;
      rnd_type hi;
      rnd_type lo;
      sample_type res;
      sum = acc + ROUND_HALF;
      q   = RND_WIDTH'(sum >>> FRAC_BITS);
      hi  = RND_WIDTH'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      lo  = -hi - RND_WIDTH'(1);
      if (q > hi) begin
         res = hi[SAMPLE_WIDTH-1:0];
      end else if (q < lo) begin
         res = lo[SAMPLE_WIDTH-1:0];
      end else begin
         res = q[SAMPLE_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

// ----- hdl/adm_req_if.sv -----
// -----------------------------------------------------------------------------
// adm_req_if
// Input frame channel: valid/ready plus eight signed samples.
// -----------------------------------------------------------------------------
interface adm_req_if import adm_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_0;
   logic signed [SAMPLE_WIDTH-1:0] sample_1;
   logic signed [SAMPLE_WIDTH-1:0] sample_2;
   logic signed [SAMPLE_WIDTH-1:0] sample_3;
   logic signed [SAMPLE_WIDTH-1:0] sample_4;
   logic signed [SAMPLE_WIDTH-1:0] sample_5;
   logic signed [SAMPLE_WIDTH-1:0] sample_6;
   logic signed [SAMPLE_WIDTH-1:0] sample_7;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, input ready);
   modport sink (input valid, sample_0, sample_1, sample_2, sample_3,
                 sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

// ----- hdl/adm_rsp_if.sv -----
// -----------------------------------------------------------------------------
// adm_rsp_if
// Mixed frame channel: valid/ready plus left, right, count and error flag.
// -----------------------------------------------------------------------------
interface adm_rsp_if import adm_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_left;
   logic signed [SAMPLE_WIDTH-1:0] out_right;
   logic [1:0]                     out_channels;
   logic                           channel_error;

   modport source (output valid, out_left, out_right, out_channels, channel_error,
                   input ready);
   modport sink (input valid, out_left, out_right, out_channels, channel_error,
                 output ready);
endinterface

// ----- hdl/adm_mix.sv -----
// -----------------------------------------------------------------------------
// adm_mix
// Two-stage mixing datapath: products and channel sum, then weight, round,
// saturate into the result register.
// -----------------------------------------------------------------------------
module adm_mix import adm_pkg::*; (
   input  logic         clock,
   input  stage_en_type stage_en,
   input  frame_type    frame,
   input  logic [1:0]   fold_mode,
   input  logic [3:0]   input_channels,
   output result_type   result
);

   typedef struct packed {
      mix_sel_type                  sel;
      logic                         err;
      logic [1:0]                   out_channels;
      logic signed [COEF_WIDTH-1:0] weight;
   } ctrl_type;

   sample_type s [NUM_SLOTS];
   sum_type    sum_in;
   acc_type    base_l_in, base_r_in;
   acc_type    prod_c_in, prod_ls_in, prod_rs_in;
   ctrl_type   ctrl_in;

   sum_type    sum_ff;
   acc_type    base_l_ff, base_r_ff;
   acc_type    prod_c_ff, prod_ls_ff, prod_rs_ff;
   sample_type mono_ff;
   ctrl_type   ctrl_ff;

   acc_type    acc_avg, acc_l, acc_r;
   result_type result_in;
   result_type result_ff;

   // Drop slots beyond the supported channel count
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         s[i] = (i < MAX_CHANNELS) ? $signed(frame[i]) : '0;
      end
   end

   // Sum of the channels present
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (4'(i) < input_channels) begin
            sum_in = sum_in + SUM_WIDTH'(s[i]);
         end
      end
   end

   always_comb begin
      acc_type rear_l;
      acc_type rear_r;
      rear_l     = (input_channels == 4'd8) ? (ACC_WIDTH'(s[6]) <<< (FRAC_BITS-1)) : '0;
      rear_r     = (input_channels == 4'd8) ? (ACC_WIDTH'(s[7]) <<< (FRAC_BITS-1)) : '0;
      base_l_in  = (ACC_WIDTH'(s[0]) <<< FRAC_BITS) + rear_l;
      base_r_in  = (ACC_WIDTH'(s[1]) <<< FRAC_BITS) + rear_r;
      prod_c_in  = ACC_WIDTH'(s[2]) * ACC_WIDTH'(COEF_SURR);
      prod_ls_in = ACC_WIDTH'(s[4]) * ACC_WIDTH'(COEF_SURR);
      prod_rs_in = ACC_WIDTH'(s[5]) * ACC_WIDTH'(COEF_SURR);
   end

   // Mode decode and channel count check
   always_comb begin
      ctrl_in.weight       = avg_weight(input_channels);
      ctrl_in.out_channels = OUT_MONO;
      ctrl_in.sel          = SEL_AVG;
      ctrl_in.err          = 1'b0;
      case (fold_mode)
         MODE_STEREO_MONO: begin
            ctrl_in.err = (input_channels != 4'd2);
         end
         MODE_MONO_STEREO: begin
            ctrl_in.sel          = SEL_DUP;
            ctrl_in.out_channels = OUT_STEREO;
            ctrl_in.err          = (input_channels != 4'd1);
         end
         MODE_SURR_STEREO: begin
            ctrl_in.sel          = SEL_SURR;
            ctrl_in.out_channels = OUT_STEREO;
            ctrl_in.err          = (input_channels != 4'd6 && input_channels != 4'd8) ||
                                   (input_channels > 4'(MAX_CHANNELS));
         end
         MODE_ANY_MONO: begin
            ctrl_in.err = (input_channels < 4'd1) ||
                          (input_channels > 4'(MAX_CHANNELS));
         end
         default: begin
            ctrl_in.err = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en.load_a) begin
         sum_ff     <= sum_in;
         base_l_ff  <= base_l_in;
         base_r_ff  <= base_r_in;
         prod_c_ff  <= prod_c_in;
         prod_ls_ff <= prod_ls_in;
         prod_rs_ff <= prod_rs_in;
         mono_ff    <= s[0];
         ctrl_ff    <= ctrl_in;
      end
   end

   always_comb begin
      acc_avg = ACC_WIDTH'(sum_ff) * ACC_WIDTH'(ctrl_ff.weight);
      acc_l   = base_l_ff + prod_c_ff + prod_ls_ff;
      acc_r   = base_r_ff + prod_c_ff + prod_rs_ff;

      result_in.out_channels  = ctrl_ff.out_channels;
      result_in.channel_error = ctrl_ff.err;
      result_in.out_left      = '0;
      result_in.out_right     = '0;
      if (!ctrl_ff.err) begin
         case (ctrl_ff.sel)
            SEL_DUP: begin
               result_in.out_left  = mono_ff;
               result_in.out_right = mono_ff;
            end
            SEL_SURR: begin
               result_in.out_left  = round_sat(acc_l);
               result_in.out_right = round_sat(acc_r);
            end
            default: begin
               result_in.out_left = round_sat(acc_avg);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.load_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- hdl/audio_channel_downmix_top.sv -----
// -----------------------------------------------------------------------------
// audio_channel_downmix_top
// Per-frame surround downmixer: stereo/mono, mono/stereo, 5.1 or 7.1 to
// stereo after BS.775, and N-channel averaging, with saturation.
// -----------------------------------------------------------------------------
// Accepts one frame transaction every clock cycle while rsp_ch.ready is high
// and returns one mixed frame transaction for each, in order. A frame is
// captured into the input register, passes the product/sum stage, and lands
// in the result register that rsp_ch presents. One frame per cycle holds
// because each stage does its work in logic ahead of its register and loads
// whenever the stage ahead hands on its contents in the same cycle; every
// stage holds its contents while the stage ahead is full and stalled, and
// empty stages keep accepting, so while a finished result waits the input
// still takes up to two further frames before req_ch.ready falls. csr_*
// writes take effect at the write edge and must be made only with no frame
// in flight. Channel counts that do not suit the mode raise channel_error
// with zero samples; out_channels still follows the mode.
// -----------------------------------------------------------------------------
module audio_channel_downmix_top import adm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   adm_req_if.sink   req_ch,
   adm_rsp_if.source rsp_ch,
   input  logic      csr_we,
   input  logic      csr_index,
   input  logic [3:0] csr_wdata
);

   logic [1:0]   fold_mode_ff, fold_mode_in;
   logic [3:0]   input_channels_ff, input_channels_in;

   logic         in_valid_ff, in_valid_in;
   logic         a_valid_ff, a_valid_in;
   logic         out_valid_ff, out_valid_in;
   frame_type    frame_ff;

   logic         ready_out, ready_a, ready_in;
   stage_en_type stage_en;
   result_type   result;

   // Configuration writes
   always_comb begin
      fold_mode_in      = fold_mode_ff;
      input_channels_in = input_channels_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FOLD_MODE:      fold_mode_in      = csr_wdata[1:0];
            CSR_INPUT_CHANNELS: input_channels_in = csr_wdata;
            default:            fold_mode_in      = fold_mode_ff;
         endcase
      end
   end

   // A stage may load when it is empty or the stage ahead takes its contents
   assign ready_out = !out_valid_ff || rsp_ch.ready;
   assign ready_a   = !a_valid_ff || ready_out;
   assign ready_in  = !in_valid_ff || ready_a;

   assign stage_en.load_a   = ready_a;
   assign stage_en.load_out = ready_out;

   assign in_valid_in  = ready_in  ? req_ch.valid : in_valid_ff;
   assign a_valid_in   = ready_a   ? in_valid_ff  : a_valid_ff;
   assign out_valid_in = ready_out ? a_valid_ff   : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_mode_ff      <= MODE_STEREO_MONO;
         input_channels_ff <= 4'd2;
         in_valid_ff       <= 1'b0;
         a_valid_ff        <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         fold_mode_ff      <= fold_mode_in;
         input_channels_ff <= input_channels_in;
         in_valid_ff       <= in_valid_in;
         a_valid_ff        <= a_valid_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   // Load the frame whenever the input register can accept; hold it otherwise
   always_ff @(posedge clock) begin
      if (ready_in) begin
         frame_ff[0] <= req_ch.sample_0;
         frame_ff[1] <= req_ch.sample_1;
         frame_ff[2] <= req_ch.sample_2;
         frame_ff[3] <= req_ch.sample_3;
         frame_ff[4] <= req_ch.sample_4;
         frame_ff[5] <= req_ch.sample_5;
         frame_ff[6] <= req_ch.sample_6;
         frame_ff[7] <= req_ch.sample_7;
      end
   end

   adm_mix u_mix (
      .clock          (clock),
      .stage_en       (stage_en),
      .frame          (frame_ff),
      .fold_mode      (fold_mode_ff),
      .input_channels (input_channels_ff),
      .result         (result)
   );

   assign req_ch.ready         = ready_in;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_left      = result.out_left;
   assign rsp_ch.out_right     = result.out_right;
   assign rsp_ch.out_channels  = result.out_channels;
   assign rsp_ch.channel_error = result.channel_error;

endmodule
